// ===== rtl/sorted_key_value_table_core_defines.svh =====
// Assertion macros for the sorted key/value table.
// Used by sorted_key_value_table_core; depends on nothing else.
`ifndef SORTED_KEY_VALUE_TABLE_CORE_DEFINES_SVH
`define SORTED_KEY_VALUE_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SKVT_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("sorted table invariant violated");
`define SKVT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted table same-cycle check failed");
`define SKVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted table next-cycle check failed");
`else
`define SKVT_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define SKVT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SKVT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/skvt_pkg.sv =====
// Shared types, constants and a helper function of the sorted key/value table.
// Used by skvt_cell and sorted_key_value_table_core; depends on nothing else.
`timescale 1ns / 1ps

package skvt_pkg;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int OP_W    = 2;
    localparam int COUNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_SEARCH = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic capture;
        logic do_ins;
        logic do_rem;
        logic do_upd;
    } cell_ctrl_t;

    // Signed order between a stored key and a probe key.
    function automatic logic order_holds(
        input logic [KEY_W-1:0] stored,
        input logic [KEY_W-1:0] probe,
        input logic             descending
    );
        logic result;
        if (descending)
        begin
            result = ($signed(stored) >= $signed(probe));
        end
        else
        begin
            result = ($signed(stored) <= $signed(probe));
        end
        return result;
    endfunction

endpackage

// ===== rtl/skvt_cell.sv =====
// One slot of the sorted key/value row: holds a pair and its compare flags.
// Depends on skvt_pkg; instantiated in a chain by sorted_key_value_table_core.
`timescale 1ns / 1ps

module skvt_cell (
    input  logic                     clk,
    input  skvt_pkg::cell_ctrl_t     ctrl,
    input  logic                     occupied,
    input  logic                     key_order,
    input  logic [skvt_pkg::KEY_W-1:0] probe_key,
    input  logic [skvt_pkg::KEY_W-1:0] new_key,
    input  logic [skvt_pkg::VAL_W-1:0] new_val,
    input  logic [skvt_pkg::KEY_W-1:0] left_key,
    input  logic [skvt_pkg::VAL_W-1:0] left_val,
    input  logic [skvt_pkg::KEY_W-1:0] right_key,
    input  logic [skvt_pkg::VAL_W-1:0] right_val,
    input  logic                     ins_seen_in,
    output logic                     ins_seen_out,
    input  logic                     rem_seen_in,
    output logic                     rem_seen_out,
    output logic [skvt_pkg::KEY_W-1:0] key_q,
    output logic [skvt_pkg::VAL_W-1:0] val_q,
    output logic                     match
);

    logic [skvt_pkg::KEY_W-1:0] key_reg;
    logic [skvt_pkg::KEY_W-1:0] key_next;
    logic [skvt_pkg::VAL_W-1:0] val_reg;
    logic [skvt_pkg::VAL_W-1:0] val_next;
    logic                       match_reg;
    logic                       match_next;
    logic                       fail_reg;
    logic                       fail_next;

    // An empty slot always counts as the place where the order fails, so the
    // first failing slot is the insert position, at most the entry count.
    always_comb
    begin
        match_next = match_reg;
        fail_next  = fail_reg;
        if (ctrl.capture)
        begin
            match_next = occupied && (key_reg == probe_key);
            fail_next  = !occupied || !skvt_pkg::order_holds(key_reg, probe_key, key_order);
        end
    end

    assign ins_seen_out = ins_seen_in | fail_reg;
    assign rem_seen_out = rem_seen_in | match_reg;

    always_comb
    begin
        key_next = key_reg;
        val_next = val_reg;
        if (ctrl.do_ins)
        begin
            if (ins_seen_in)
            begin
                key_next = left_key;
                val_next = left_val;
            end
            else if (fail_reg)
            begin
                key_next = new_key;
                val_next = new_val;
            end
        end
        else if (ctrl.do_rem)
        begin
            if (rem_seen_out)
            begin
                key_next = right_key;
                val_next = right_val;
            end
        end
        else if (ctrl.do_upd)
        begin
            if (match_reg)
            begin
                val_next = new_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        val_reg   <= val_next;
        match_reg <= match_next;
        fail_reg  <= fail_next;
    end

    assign key_q = key_reg;
    assign val_q = val_reg;
    assign match = match_reg;

endmodule

// ===== rtl/sorted_key_value_table_core.sv =====
// Sorted key/value table: controller, result register and the row of cells.
// Depends on skvt_pkg, skvt_cell and sorted_key_value_table_core_defines.svh.
//
// Usage:
// The command channel (cmd_valid, cmd_stall, op, key, value) carries one
// add, search or remove per transaction; each command yields one response
// transaction on the response channel (rsp_valid, rsp_stall, found,
// old_value, entry_count, empty_res, full_reject).
// In the accept cycle every cell compares its stored key with the broadcast
// key; in the EXEC state that follows, once the response register is free,
// the row shifts to insert or close a gap and the response is written to the
// output register. A command thus passes through a compare step and a shift
// step of the cell row. A new command is taken only once the previous one
// has left the EXEC state; cmd_stall is high until then.
// A waiting response does not block the next command; only when a second
// response is ready while the first is still stalled does the table hold
// its update and keep cmd_stall high until the response register frees.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) sets the key
// order (0 ascending, 1 descending); it is always ready and is meant to be
// written only while the table is idle.
// Reset empties the table and selects ascending order; no clearing pass.
`timescale 1ns / 1ps
`include "sorted_key_value_table_core_defines.svh"

module sorted_key_value_table_core #(
    parameter int CAPACITY = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  logic [skvt_pkg::OP_W-1:0]         op,
    input  logic signed [skvt_pkg::KEY_W-1:0] key,
    input  logic signed [skvt_pkg::VAL_W-1:0] value,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic                              found,
    output logic signed [skvt_pkg::VAL_W-1:0] old_value,
    output logic [skvt_pkg::COUNT_W-1:0]      entry_count,
    output logic                              empty_res,
    output logic                              full_reject,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data
);

    localparam int CW = $clog2(CAPACITY + 1);

    skvt_pkg::state_t state_reg;
    skvt_pkg::state_t state_next;

    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic                         key_order_reg;
    logic [skvt_pkg::OP_W-1:0]    op_reg;
    logic [skvt_pkg::KEY_W-1:0]   cmd_key_reg;
    logic [skvt_pkg::VAL_W-1:0]   cmd_val_reg;

    logic                         rsp_valid_reg;
    logic                         rsp_valid_next;
    logic                         found_reg;
    logic [skvt_pkg::VAL_W-1:0]   old_value_reg;
    logic                         reject_reg;

    skvt_pkg::cell_ctrl_t         ctrl;
    logic                         fire;
    logic                         any_match;
    logic                         table_full;
    logic                         res_found;
    logic                         res_reject;
    logic [skvt_pkg::VAL_W-1:0]   matched_val;

    logic [skvt_pkg::KEY_W-1:0]   key_arr [CAPACITY];
    logic [skvt_pkg::VAL_W-1:0]   val_arr [CAPACITY];
    logic [CAPACITY-1:0]          match_vec;
    logic [CAPACITY:0]            ins_seen;
    logic [CAPACITY:0]            rem_seen;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_order_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            key_order_reg <= cfg_data;
        end
    end

    // ---------------- cell row ----------------
    assign ins_seen[0] = 1'b0;
    assign rem_seen[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [skvt_pkg::KEY_W-1:0] lk;
        logic [skvt_pkg::VAL_W-1:0] lv;
        logic [skvt_pkg::KEY_W-1:0] rk;
        logic [skvt_pkg::VAL_W-1:0] rv;

        if (i == 0)
        begin : g_left_edge
            assign lk = cmd_key_reg;
            assign lv = cmd_val_reg;
        end
        else
        begin : g_left
            assign lk = key_arr[i-1];
            assign lv = val_arr[i-1];
        end

        // The last slot has nothing to its right; it keeps its own pair.
        if (i == CAPACITY - 1)
        begin : g_right_edge
            assign rk = key_arr[i];
            assign rv = val_arr[i];
        end
        else
        begin : g_right
            assign rk = key_arr[i+1];
            assign rv = val_arr[i+1];
        end

        skvt_cell u_cell (
            .clk          (clk),
            .ctrl         (ctrl),
            .occupied     (CW'(i) < count_reg),
            .key_order    (key_order_reg),
            .probe_key    (key),
            .new_key      (cmd_key_reg),
            .new_val      (cmd_val_reg),
            .left_key     (lk),
            .left_val     (lv),
            .right_key    (rk),
            .right_val    (rv),
            .ins_seen_in  (ins_seen[i]),
            .ins_seen_out (ins_seen[i+1]),
            .rem_seen_in  (rem_seen[i]),
            .rem_seen_out (rem_seen[i+1]),
            .key_q        (key_arr[i]),
            .val_q        (val_arr[i]),
            .match        (match_vec[i])
        );
    end

    // Keys are unique, so at most one cell matches and an OR picks its value.
    always_comb
    begin
        matched_val = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            matched_val = matched_val | (val_arr[i] & {skvt_pkg::VAL_W{match_vec[i]}});
        end
    end

    assign any_match  = |match_vec;
    assign table_full = (count_reg == CW'(CAPACITY));

    // ---------------- control ----------------
    assign fire      = (state_reg == skvt_pkg::ST_EXEC) && (!rsp_valid_reg || !rsp_stall);
    assign cmd_stall = (state_reg != skvt_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skvt_pkg::ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ctrl         = '0;
        count_next   = count_reg;
        res_found    = 1'b0;
        res_reject   = 1'b0;
        case (state_reg)
            skvt_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = skvt_pkg::ST_EXEC;
                end
            end
            skvt_pkg::ST_EXEC:
            begin
                case (op_reg)
                    skvt_pkg::OP_ADD:
                    begin
                        if (any_match)
                        begin
                            res_found   = 1'b1;
                            ctrl.do_upd = fire;
                        end
                        else if (table_full)
                        begin
                            res_reject = 1'b1;
                        end
                        else
                        begin
                            ctrl.do_ins = fire;
                            if (fire)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                    end
                    skvt_pkg::OP_SEARCH:
                    begin
                        res_found = any_match;
                    end
                    skvt_pkg::OP_REMOVE:
                    begin
                        if (any_match)
                        begin
                            res_found   = 1'b1;
                            ctrl.do_rem = fire;
                            if (fire)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        res_found = 1'b0;
                    end
                endcase
                if (fire)
                begin
                    state_next = skvt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = skvt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Command payload and response payload need no reset.
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            op_reg      <= op;
            cmd_key_reg <= key;
            cmd_val_reg <= value;
        end
        if (fire)
        begin
            found_reg     <= res_found;
            old_value_reg <= res_found ? matched_val : '0;
            reject_reg    <= res_reject;
        end
    end

    // The count register only changes at the edge that loads a response, so
    // it already holds the post-operation count while the response is shown.
    logic [CW-1:0] rsp_count_reg;

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_count_reg <= count_next;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign found       = found_reg;
    assign old_value   = old_value_reg;
    assign entry_count = skvt_pkg::COUNT_W'(rsp_count_reg);
    assign empty_res   = (rsp_count_reg == '0);
    assign full_reject = reject_reg;

    // ---------------- assertions ----------------
    `SKVT_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CW'(CAPACITY))
    `SKVT_ASSERT_IMPLY(a_unique_match, clk, rst_n, state_reg == skvt_pkg::ST_EXEC, $onehot0(match_vec))
    `SKVT_ASSERT_NEXT(a_insert_grows, clk, rst_n, ctrl.do_ins, count_reg == $past(count_reg) + 1'b1)
    `SKVT_ASSERT_IMPLY(a_reject_not_found, clk, rst_n, rsp_valid_reg, !(found_reg && reject_reg))

endmodule
